>>> hdl/asat_pkg.sv
package asat_pkg;

    // Sample format and seed table size
    localparam int SAMPLE_BITS      = 24;
    localparam int RSQRT_TABLE_BITS = 8;
    localparam int FRAC             = SAMPLE_BITS - 1;
    localparam int TDATA_W          = ((SAMPLE_BITS + 7) / 8) * 8;

    // Configuration register widths
    localparam int GAIN_W     = 17;
    localparam int BIAS_W     = 16;
    localparam int MIX_W      = 17;
    localparam int LEVEL_W    = 16;
    localparam int CFG_DATA_W = 17;
    localparam int CFG_IDX_W  = 3;

    localparam int BIAS_LIM = 16384;
    localparam int MIX_FULL = 65536;

    // Datapath widths
    localparam int S_W    = SAMPLE_BITS + 1;    // x + bias
    localparam int GP_W   = S_W + GAIN_W + 1;   // (x + bias) * gain
    localparam int U_W    = GP_W - 8;           // driven sample u
    localparam int A_W    = SAMPLE_BITS + 10;   // |u|
    localparam int Y_W    = SAMPLE_BITS + 1;    // shaped value, +-unity
    localparam int A20_W  = 31;                 // |u| in Q.20
    localparam int W_W    = 63;                 // u^2 + 1 in Q.40
    localparam int K_W    = 4;                  // half exponent of w
    localparam int M_W    = 32;                 // mantissa in Q2.30
    localparam int R_W    = 32;                 // reciprocal root in Q.30
    localparam int T_W    = 34;                 // Newton scratch
    localparam int SEED_W = 17;
    localparam int SEED_N = 1 << RSQRT_TABLE_BITS;
    localparam int NEWTON_N = 2;

    localparam longint UNITY     = longint'(1) << FRAC;
    localparam longint THREE_Q30 = longint'(3) << 30;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE      = 3'd0,
        REG_GAIN      = 3'd1,
        REG_BIAS      = 3'd2,
        REG_MIX       = 3'd3,
        REG_OUT_LEVEL = 3'd4
    } asat_reg_t;

    typedef enum logic {
        MODE_TAPE = 1'b0,
        MODE_HARD = 1'b1
    } asat_mode_t;

    typedef struct packed {
        asat_mode_t                 mode;
        logic [GAIN_W-1:0]          gain;
        logic signed [BIAS_W-1:0]   bias;
        logic [MIX_W-1:0]           mix;
        logic [LEVEL_W-1:0]         out_level;
    } asat_cfg_t;

    // Fields that ride along with a sample through the shaper
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] x;
        logic                          last;
        logic                          neg;
        logic signed [Y_W-1:0]         y_hard;
    } asat_side_t;

    typedef struct packed {
        asat_side_t        side;
        logic [A_W-1:0]    mag;
    } asat_front_t;

    typedef struct packed {
        asat_side_t        side;
        logic [A_W-1:0]    mag;     // |u| >> k
        logic [R_W-1:0]    rsq;     // 1/sqrt(mantissa) in Q.30
    } asat_root_t;

    // Seed table: largest r in Q.16 with r*r*c <= 2^48, c the bin midpoint
    typedef logic [SEED_W-1:0] seed_tab_t [SEED_N];

    function automatic seed_tab_t build_seeds();
        seed_tab_t   tab;
        logic [63:0] c;
        logic [63:0] cand;
        logic [63:0] r;
        for (int i = 0; i < SEED_N; i++) begin
            c = 64'(2 * i + 1) << (17 - RSQRT_TABLE_BITS);
            r = '0;
            for (int b = 16; b >= 0; b--) begin
                cand = r | (64'd1 << b);
                if (cand <= 64'd65536 && cand * cand * c <= (64'd1 << 48)) begin
                    r = cand;
                end
            end
            tab[i] = r[SEED_W-1:0];
        end
        return tab;
    endfunction

    localparam seed_tab_t RSQRT_SEED = build_seeds();

endpackage

>>> hdl/asat_front.sv
module asat_front
    import asat_pkg::*;
(
    input  logic                          aclk,
    input  logic                          aresetn,
    input  asat_cfg_t                     cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] in_sample,
    input  logic                          in_last,
    output logic                          out_valid,
    input  logic                          out_ready,
    output asat_front_t                   out_item
);

    localparam int NSTG = 4;

    logic [NSTG-1:0] vld_reg;
    logic [NSTG:0]   rdy;
    logic [NSTG-1:0] vld_in;

    logic signed [SAMPLE_BITS-1:0] x_reg [NSTG-1];
    logic                          last_reg [NSTG-1];
    logic signed [S_W-1:0]         s0_reg;
    logic signed [GP_W-1:0]        gp1_reg;
    logic signed [U_W-1:0]         u2_reg;
    asat_front_t                   item3_reg;

    logic signed [BIAS_W-1:0] bias_sat;
    logic signed [S_W-1:0]    s_next;
    logic signed [GP_W-1:0]   gp_next;
    logic signed [U_W-1:0]    u_next;
    asat_front_t              item_next;

    always_comb begin
        rdy[NSTG] = out_ready;
        for (int i = NSTG - 1; i >= 0; i--) begin
            rdy[i] = ~vld_reg[i] | rdy[i+1];
        end
    end

    assign vld_in    = {vld_reg[NSTG-2:0], in_valid};
    assign in_ready  = rdy[0];
    assign out_valid = vld_reg[NSTG-1];
    assign out_item  = item3_reg;

    always_comb begin
        // saturate bias to +-1.0 in Q2.14
        if (cfg.bias > $signed(BIAS_W'(BIAS_LIM))) begin
            bias_sat = BIAS_W'(BIAS_LIM);
        end else if (cfg.bias < -$signed(BIAS_W'(BIAS_LIM))) begin
            bias_sat = -$signed(BIAS_W'(BIAS_LIM));
        end else begin
            bias_sat = cfg.bias;
        end
        s_next  = S_W'(in_sample) + (S_W'(bias_sat) <<< (FRAC - 14));
        gp_next = GP_W'(s0_reg) * GP_W'($signed({1'b0, cfg.gain}));
        u_next  = U_W'((gp1_reg + GP_W'(128)) >>> 8);

        item_next.side.x    = x_reg[NSTG-2];
        item_next.side.last = last_reg[NSTG-2];
        item_next.side.neg  = u2_reg[U_W-1];
        item_next.mag       = u2_reg[U_W-1] ? A_W'(-u2_reg) : A_W'(u2_reg);
        if (u2_reg > $signed(U_W'(UNITY))) begin
            item_next.side.y_hard = Y_W'(UNITY);
        end else if (u2_reg < -$signed(U_W'(UNITY))) begin
            item_next.side.y_hard = -$signed(Y_W'(UNITY));
        end else begin
            item_next.side.y_hard = Y_W'(u2_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int i = 0; i < NSTG; i++) begin
                if (rdy[i]) begin
                    vld_reg[i] <= vld_in[i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            s0_reg      <= s_next;
            x_reg[0]    <= in_sample;
            last_reg[0] <= in_last;
        end
        if (rdy[1]) begin
            gp1_reg     <= gp_next;
            x_reg[1]    <= x_reg[0];
            last_reg[1] <= last_reg[0];
        end
        if (rdy[2]) begin
            u2_reg      <= u_next;
            x_reg[2]    <= x_reg[1];
            last_reg[2] <= last_reg[1];
        end
        if (rdy[3]) begin
            item3_reg   <= item_next;
        end
    end

endmodule

>>> hdl/asat_rsqrt.sv
module asat_rsqrt
    import asat_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  asat_front_t in_item,
    output logic        out_valid,
    input  logic        out_ready,
    output asat_root_t  out_item
);

    localparam int NSTG = 4 + 4 * NEWTON_N;

    typedef struct packed {
        asat_side_t        side;
        logic [A_W-1:0]    mag;
        logic [W_W-1:0]    w;
        logic [K_W-1:0]    k;
        logic [M_W-1:0]    m;
        logic [R_W-1:0]    r;
        logic [T_W-1:0]    aux;
    } stage_t;

    logic [NSTG-1:0] vld_reg;
    logic [NSTG:0]   rdy;
    logic [NSTG-1:0] vld_in;
    stage_t          stg_reg  [NSTG];
    stage_t          stg_next [NSTG];

    always_comb begin
        rdy[NSTG] = out_ready;
        for (int i = NSTG - 1; i >= 0; i--) begin
            rdy[i] = ~vld_reg[i] | rdy[i+1];
        end
    end

    assign vld_in        = {vld_reg[NSTG-2:0], in_valid};
    assign in_ready      = rdy[0];
    assign out_valid     = vld_reg[NSTG-1];
    assign out_item.side = stg_reg[NSTG-1].side;
    assign out_item.mag  = stg_reg[NSTG-1].mag;
    assign out_item.rsq  = stg_reg[NSTG-1].r;

    always_comb begin
        logic [63:0]        a_wide;
        logic [A20_W-1:0]   a20;
        logic [2*A20_W-1:0] a_sq;
        logic [K_W-1:0]     k_top;
        logic [63:0]        sq_p [NEWTON_N];
        logic [63:0]        mt_p [NEWTON_N];
        logic [63:0]        rd_p [NEWTON_N];
        int                 b;

        // w = |u|^2 + 1 in Q.40
        stg_next[0]      = '0;
        stg_next[0].side = in_item.side;
        stg_next[0].mag  = in_item.mag;
        a_wide           = 64'(in_item.mag) << (31 - FRAC);
        a20              = A20_W'(a_wide >> 11);
        a_sq             = (2*A20_W)'(a20) * (2*A20_W)'(a20);
        stg_next[0].w    = W_W'(a_sq) + (W_W'(1) << 40);

        // half exponent from the leading one of w
        stg_next[1] = stg_reg[0];
        k_top       = '0;
        for (int j = 0; j <= W_W - 41; j++) begin
            if (stg_reg[0].w[40 + j]) begin
                k_top = K_W'(j >> 1);
            end
        end
        stg_next[1].k = k_top;

        // normalize to a mantissa in [1,4) and scale |u| to match
        stg_next[2]     = stg_reg[1];
        stg_next[2].m   = M_W'(stg_reg[1].w >> (10 + 2 * stg_reg[1].k));
        stg_next[2].mag = stg_reg[1].mag >> stg_reg[1].k;

        // seed from the table, taken to Q.30
        stg_next[3]   = stg_reg[2];
        stg_next[3].r = R_W'(RSQRT_SEED[stg_reg[2].m[M_W-1 -: RSQRT_TABLE_BITS]]) << 14;

        // Newton steps: r2, t, d, then r
        for (int it = 0; it < NEWTON_N; it++) begin
            b = 4 + 4 * it;

            stg_next[b]     = stg_reg[b-1];
            sq_p[it]        = 64'(stg_reg[b-1].r) * 64'(stg_reg[b-1].r);
            stg_next[b].aux = T_W'(sq_p[it][63:30]);

            stg_next[b+1]     = stg_reg[b];
            mt_p[it]          = 64'(stg_reg[b].m) * 64'(stg_reg[b].aux[R_W-1:0]);
            stg_next[b+1].aux = T_W'(mt_p[it][63:30]);

            stg_next[b+2] = stg_reg[b+1];
            if (stg_reg[b+1].aux >= T_W'(THREE_Q30)) begin
                stg_next[b+2].aux = '0;
            end else begin
                stg_next[b+2].aux = T_W'(THREE_Q30) - stg_reg[b+1].aux;
            end

            stg_next[b+3]   = stg_reg[b+2];
            rd_p[it]        = 64'(stg_reg[b+2].r) * 64'(stg_reg[b+2].aux[R_W-1:0]);
            stg_next[b+3].r = rd_p[it][62:31];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int i = 0; i < NSTG; i++) begin
                if (rdy[i]) begin
                    vld_reg[i] <= vld_in[i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < NSTG; i++) begin
            if (rdy[i]) begin
                stg_reg[i] <= stg_next[i];
            end
        end
    end

endmodule

>>> hdl/asat_blend.sv
module asat_blend
    import asat_pkg::*;
(
    input  logic                          aclk,
    input  logic                          aresetn,
    input  asat_cfg_t                     cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  asat_root_t                    in_item,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0] out_sample,
    output logic                          out_last,
    output logic                          out_clip
);

    localparam int NSTG  = 7;
    localparam int PR_W  = A_W + R_W;
    localparam int WET_W = Y_W + MIX_W + 1;
    localparam int LP_W  = Y_W + LEVEL_W + 1;
    localparam int O_W   = LP_W - 12;

    typedef struct packed {
        asat_side_t                    side;
        logic [A_W-1:0]                mag;
        logic [R_W-1:0]                rsq;
        logic [PR_W-1:0]               prod;
        logic [SAMPLE_BITS-1:0]        ymag;
        logic signed [Y_W-1:0]         y;
        logic signed [WET_W-1:0]       wet;
        logic signed [WET_W-1:0]       dry;
        logic signed [Y_W-1:0]         z;
        logic signed [LP_W-1:0]        lp;
        logic signed [SAMPLE_BITS-1:0] o;
        logic                          clip;
    } stage_t;

    logic [NSTG-1:0] vld_reg;
    logic [NSTG:0]   rdy;
    logic [NSTG-1:0] vld_in;
    stage_t          stg_reg  [NSTG];
    stage_t          stg_next [NSTG];

    always_comb begin
        rdy[NSTG] = out_ready;
        for (int i = NSTG - 1; i >= 0; i--) begin
            rdy[i] = ~vld_reg[i] | rdy[i+1];
        end
    end

    assign vld_in     = {vld_reg[NSTG-2:0], in_valid};
    assign in_ready   = rdy[0];
    assign out_valid  = vld_reg[NSTG-1];
    assign out_sample = stg_reg[NSTG-1].o;
    assign out_last   = stg_reg[NSTG-1].side.last;
    assign out_clip   = stg_reg[NSTG-1].clip;

    always_comb begin
        logic [PR_W:0]               ysum;
        logic [PR_W-29:0]            yq;
        logic signed [Y_W-1:0]       y_soft;
        logic [MIX_W-1:0]            mx;
        logic signed [WET_W-1:0]     zsum;
        logic signed [O_W-1:0]       os;

        // soft clip magnitude: (|u| >> k) * r, rounded, capped at unity
        stg_next[0]      = '0;
        stg_next[0].side = in_item.side;
        stg_next[0].prod = PR_W'(in_item.mag) * PR_W'(in_item.rsq);

        stg_next[1] = stg_reg[0];
        ysum        = (PR_W + 1)'(stg_reg[0].prod) + ((PR_W + 1)'(1) << 29);
        yq          = (PR_W - 28)'(ysum >> 30);
        if (yq > (PR_W - 28)'(UNITY)) begin
            stg_next[1].ymag = SAMPLE_BITS'(UNITY);
        end else begin
            stg_next[1].ymag = yq[SAMPLE_BITS-1:0];
        end

        // restore sign, pick the curve
        stg_next[2] = stg_reg[1];
        y_soft      = stg_reg[1].side.neg ? -$signed({1'b0, stg_reg[1].ymag})
                                          :  $signed({1'b0, stg_reg[1].ymag});
        stg_next[2].y = (cfg.mode == MODE_HARD) ? stg_reg[1].side.y_hard : y_soft;

        // wet and dry products
        stg_next[3] = stg_reg[2];
        mx = (cfg.mix > MIX_W'(MIX_FULL)) ? MIX_W'(MIX_FULL) : cfg.mix;
        stg_next[3].wet = WET_W'($signed(stg_reg[2].y)) * WET_W'($signed({1'b0, mx}));
        stg_next[3].dry = WET_W'($signed(stg_reg[2].side.x))
                        * WET_W'($signed({1'b0, MIX_W'(MIX_FULL) - mx}));

        stg_next[4]   = stg_reg[3];
        zsum          = $signed(stg_reg[3].wet) + $signed(stg_reg[3].dry)
                      + $signed(WET_W'(32768));
        stg_next[4].z = Y_W'(zsum >>> 16);

        // output level; a level of zero yields exactly zero here
        stg_next[5]    = stg_reg[4];
        stg_next[5].lp = LP_W'($signed(stg_reg[4].z)) * LP_W'($signed({1'b0, cfg.out_level}));

        stg_next[6] = stg_reg[5];
        os          = O_W'(($signed(stg_reg[5].lp) + $signed(LP_W'(2048))) >>> 12);
        if (os > $signed(O_W'(UNITY - 1))) begin
            stg_next[6].o    = SAMPLE_BITS'(UNITY - 1);
            stg_next[6].clip = 1'b1;
        end else if (os < -$signed(O_W'(UNITY))) begin
            stg_next[6].o    = SAMPLE_BITS'(-UNITY);
            stg_next[6].clip = 1'b1;
        end else begin
            stg_next[6].o    = os[SAMPLE_BITS-1:0];
            stg_next[6].clip = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int i = 0; i < NSTG; i++) begin
                if (rdy[i]) begin
                    vld_reg[i] <= vld_in[i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < NSTG; i++) begin
            if (rdy[i]) begin
                stg_reg[i] <= stg_next[i];
            end
        end
    end

endmodule

>>> hdl/audio_saturator.sv
// Channel   Dir  Ports                               Contents
// --------  ---  ----------------------------------  ---------------------------------------
// input     in   s_tvalid s_tready s_tdata s_tlast   tdata: sample_in; tlast: last_in
// result    out  m_tvalid m_tready m_tdata m_tlast   tdata: sample_out; tlast: last_out;
//                m_tuser                             tuser: clipped
// config    in   cfg_wr_en cfg_wr_index cfg_wr_data  mode, gain, bias, mix, out_level
//
// One sample per cycle sustained while m_tready is high; each sample passes through
// 4 drive stages, 12 reciprocal-root stages (square, half exponent, normalize, seed,
// two 4-stage Newton steps) and 7 shaping, blend and level stages; every stage holds
// one multiplier at most, but for the blend stage that forms the wet and dry products
// side by side. Reset empties the pipeline and loads the register defaults.
// Every stage carries its own valid bit; a stage loads whenever it is empty or its
// content moves on, so bubbles close up under a stall and s_tready drops only when all
// 23 stages hold samples while m_tready is low.
module audio_saturator
    import asat_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [TDATA_W-1:0]    s_tdata,      // [SAMPLE_BITS-1:0] sample_in
    input  logic                  s_tlast,

    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [TDATA_W-1:0]    m_tdata,      // [SAMPLE_BITS-1:0] sample_out, zero pad above
    output logic                  m_tlast,
    output logic [0:0]            m_tuser       // [0] clipped
);

    localparam logic [SAMPLE_BITS-1:0] SAT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] SAT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // Control registers, applied at once
    asat_mode_t                 mode_reg;
    logic [GAIN_W-1:0]          gain_reg;
    logic signed [BIAS_W-1:0]   bias_reg;
    logic [MIX_W-1:0]           mix_reg;
    logic [LEVEL_W-1:0]         level_reg;
    asat_cfg_t                  cfg;

    logic                          fr_valid;
    logic                          fr_ready;
    asat_front_t                   fr_item;
    logic                          rt_valid;
    logic                          rt_ready;
    asat_root_t                    rt_item;
    logic signed [SAMPLE_BITS-1:0] res_sample;

    // Decode register writes; unknown indexes drop the write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_TAPE;
            gain_reg  <= GAIN_W'(256);
            bias_reg  <= '0;
            mix_reg   <= MIX_W'(MIX_FULL);
            level_reg <= LEVEL_W'(4096);
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                REG_MODE:      mode_reg  <= asat_mode_t'(cfg_wr_data[0]);
                REG_GAIN:      gain_reg  <= cfg_wr_data[GAIN_W-1:0];
                REG_BIAS:      bias_reg  <= cfg_wr_data[BIAS_W-1:0];
                REG_MIX:       mix_reg   <= cfg_wr_data[MIX_W-1:0];
                REG_OUT_LEVEL: level_reg <= cfg_wr_data[LEVEL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign cfg.mode      = mode_reg;
    assign cfg.gain      = gain_reg;
    assign cfg.bias      = bias_reg;
    assign cfg.mix       = mix_reg;
    assign cfg.out_level = level_reg;

    // Drive: bias, gain, round, split into sign and magnitude, hard clamp
    asat_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_sample ($signed(s_tdata[SAMPLE_BITS-1:0])),
        .in_last   (s_tlast),
        .out_valid (fr_valid),
        .out_ready (fr_ready),
        .out_item  (fr_item)
    );

    // Soft clip denominator: 1/sqrt(u^2 + 1) by seed and Newton refinement
    asat_rsqrt u_rsqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_item   (fr_item),
        .out_valid (rt_valid),
        .out_ready (rt_ready),
        .out_item  (rt_item)
    );

    // Shape, dry/wet blend, output level, saturate; last stage is the output register
    asat_blend u_blend (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .in_valid   (rt_valid),
        .in_ready   (rt_ready),
        .in_item    (rt_item),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_sample (res_sample),
        .out_last   (m_tlast),
        .out_clip   (m_tuser[0])
    );

    assign m_tdata = TDATA_W'($unsigned(res_sample));

    // A clipped result always sits at one of the two rails
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |->
            (m_tdata[SAMPLE_BITS-1:0] == SAT_MAX) || (m_tdata[SAMPLE_BITS-1:0] == SAT_MIN))
        else $error("clipped flag set on an unsaturated result");

    // Input back-pressure only comes from a held result
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled while the output is free");

    // Reset drains every stage
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

>>> dv/tb.sv
module tb;
    import asat_pkg::*;

    // Pipeline depth of the block, from request to result
    localparam int PIPE_DEPTH = 23;
    // Longest run of idle cycles the source inserts before one request
    localparam int MAX_SRC_GAP = 12;

    localparam logic signed [SAMPLE_BITS-1:0] X_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] X_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // One shaped sample as it should leave the block
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          last;
        logic                          clip;
    } shaped_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_wr_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [TDATA_W-1:0]    s_tdata = '0;        // [SAMPLE_BITS-1:0] sample_in
    logic                  s_tlast = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [TDATA_W-1:0]    m_tdata;             // [SAMPLE_BITS-1:0] sample_out
    logic                  m_tlast;
    logic [0:0]            m_tuser;             // [0] clipped

    // Register mirror used by the shaper model
    asat_mode_t               cur_mode  = MODE_TAPE;
    logic [GAIN_W-1:0]        cur_gain  = 17'd256;
    logic signed [BIAS_W-1:0] cur_bias  = '0;
    logic [MIX_W-1:0]         cur_mix   = 17'd65536;
    logic [LEVEL_W-1:0]       cur_level = 16'd4096;

    // Reciprocal-root seeds in Q.16, one per mantissa bin
    bit [16:0] rsqrt_seed [SEED_N];

    shaped_t shaped_samples [$];
    int      fail_count    = 0;
    int      src_idle_pct  = 0;
    int      sink_idle_pct = 0;

    audio_saturator i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tlast      (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .m_tuser      (m_tuser)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Hard stop well past the slowest legal run
    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    // Seed bin i covers mantissas around the midpoint (2i+1)/2^(TABLE_BITS-1); find the
    // largest r with r*r*c <= 2^48 by starting from a real estimate and nudging.
    task automatic fill_seed_table();
        bit [63:0] c;
        bit [63:0] r;
        bit [63:0] lim;
        lim = 64'd1 << 48;
        for (int i = 0; i < SEED_N; i++) begin
            c = 64'(2 * i + 1) << (17 - RSQRT_TABLE_BITS);
            r = 64'($rtoi($sqrt((2.0 ** 48) / real'(c))));
            if (r > 64'd65536) r = 64'd65536;
            while (r * r * c > lim) r = r - 1;
            while (r < 64'd65536 && (r + 1) * (r + 1) * c <= lim) r = r + 1;
            rsqrt_seed[i] = r[16:0];
        end
    endtask

    // Soft clip u/sqrt(u^2+1): normalize u^2+1 to a mantissa in [1,4), seed from the
    // table, refine with two Newton steps, then scale |u| back by the half exponent.
    function automatic longint tape_curve(longint u);
        bit [63:0] a, a20, w, m, r, r2, t, d, mag;
        bit [63:0] three;
        int        p, k;
        three = 64'd3 << 30;
        a     = (u < 0) ? -u : u;
        a20   = (a << (31 - FRAC)) >> 11;
        w     = a20 * a20 + (64'd1 << 40);
        p     = 40;
        while (p < 62 && (w >> (p + 1)) != 0) p++;
        k = (p - 40) / 2;
        m = w >> (10 + 2 * k);
        r = 64'(rsqrt_seed[int'((m >> (32 - RSQRT_TABLE_BITS)) & (SEED_N - 1))]) << 14;
        for (int n = 0; n < NEWTON_N; n++) begin
            r2 = (r * r) >> 30;
            t  = (m * r2) >> 30;
            d  = (t >= three) ? 64'd0 : three - t;
            r  = (r * d) >> 31;
        end
        mag = ((a >> k) * r + (64'd1 << 29)) >> 30;
        if (mag > UNITY) mag = UNITY;
        return (u < 0) ? -longint'(mag) : longint'(mag);
    endfunction

    // Drive, shape, blend with the dry sample, apply the level, saturate
    function automatic shaped_t shape_sample(logic signed [SAMPLE_BITS-1:0] x_in, logic last_in);
        longint  x, b, g, mx, lvl, s, u, y, z, o;
        shaped_t res;
        x   = x_in;
        b   = cur_bias;
        g   = cur_gain;
        lvl = cur_level;
        mx  = cur_mix;
        if (b > BIAS_LIM) b = BIAS_LIM;
        if (b < -BIAS_LIM) b = -BIAS_LIM;
        if (mx > MIX_FULL) mx = MIX_FULL;
        s = x + b * (longint'(1) << (FRAC - 14));
        u = (s * g + 128) >>> 8;
        if (cur_mode == MODE_HARD) begin
            y = u;
            if (y > UNITY) y = UNITY;
            if (y < -UNITY) y = -UNITY;
        end else begin
            y = tape_curve(u);
        end
        z = (y * mx + x * (MIX_FULL - mx) + (longint'(1) << 15)) >>> 16;
        o = (z * lvl + 2048) >>> 12;
        if (lvl == 0) o = 0;
        res.clip = 1'b0;
        if (o > UNITY - 1) begin
            o = UNITY - 1;
            res.clip = 1'b1;
        end
        if (o < -UNITY) begin
            o = -UNITY;
            res.clip = 1'b1;
        end
        res.sample = o[SAMPLE_BITS-1:0];
        res.last   = last_in;
        return res;
    endfunction

    // Write one register; the enable stays high so back-to-back writes need one
    // assignment per step. Lower it with the next call or with close_cfg.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= data;
        case (idx)
            REG_MODE:      cur_mode  = asat_mode_t'(data[0]);
            REG_GAIN:      cur_gain  = data[GAIN_W-1:0];
            REG_BIAS:      cur_bias  = data[BIAS_W-1:0];
            REG_MIX:       cur_mix   = data[MIX_W-1:0];
            REG_OUT_LEVEL: cur_level = data[LEVEL_W-1:0];
            default: ;
        endcase
    endtask

    task automatic close_cfg();
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic apply_cfg(asat_mode_t mode_v, int gain_v, int bias_v, int mix_v, int level_v);
        write_reg(REG_MODE, CFG_DATA_W'(mode_v));
        write_reg(REG_GAIN, CFG_DATA_W'(gain_v));
        write_reg(REG_BIAS, CFG_DATA_W'(bias_v));
        write_reg(REG_MIX, CFG_DATA_W'(mix_v));
        write_reg(REG_OUT_LEVEL, CFG_DATA_W'(level_v));
        close_cfg();
    endtask

    // Offer one request, with a random gap ahead of it, and hold it until taken.
    // Returns in the step of the accepting edge with s_tvalid still high.
    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] x, input logic last);
        int                 gap;
        logic [TDATA_W-1:0] word;
        gap = 0;
        while (gap < MAX_SRC_GAP && $urandom_range(99) < src_idle_pct) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        word                  = '0;
        word[SAMPLE_BITS-1:0] = x;
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        shaped_samples.push_back(shape_sample(x, last));
    endtask

    // Drop valid and wait until every pending request has come back
    task automatic settle();
        s_tvalid <= 1'b0;
        while (shaped_samples.size() != 0) @(posedge aclk);
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(9))
            0:       return X_MAX;
            1:       return X_MIN;
            2:       return SAMPLE_BITS'($signed($urandom_range(8191)) - 4096);
            3:       return SAMPLE_BITS'($urandom_range(3) - 2);
            default: return SAMPLE_BITS'($urandom());
        endcase
    endfunction

    // Reset values: tape, unity gain, no bias, fully wet, unity level
    task automatic test_reset_defaults();
        send_sample(X_MAX, 1'b0);
        send_sample(X_MIN, 1'b0);
        send_sample('0, 1'b0);
        send_sample(-1, 1'b1);
        settle();
    endtask

    // Largest drive and level on both curves, with full positive then full negative bias
    task automatic test_drive_extremes();
        apply_cfg(MODE_HARD, 77056, 16384, 65536, 64918);
        send_sample(X_MAX, 1'b0);
        send_sample(X_MIN, 1'b1);
        send_sample(SAMPLE_BITS'(-16384 * 512), 1'b0);
        settle();
        apply_cfg(MODE_TAPE, 77056, -16384, 65536, 64918);
        send_sample(X_MAX, 1'b0);
        send_sample(X_MIN, 1'b0);
        send_sample(SAMPLE_BITS'(16384 * 512), 1'b1);
        settle();
    endtask

    // Level zero must give zero and never flag clipping
    task automatic test_mute();
        apply_cfg(MODE_HARD, 77056, 16384, 65536, 0);
        send_sample(X_MAX, 1'b0);
        send_sample(X_MIN, 1'b1);
        settle();
    endtask

    // Bias, mix and gain codes outside their nominal ranges
    task automatic test_out_of_range_regs();
        apply_cfg(MODE_TAPE, 4096, -32768, 65536, 4096);
        send_sample(SAMPLE_BITS'(12345), 1'b0);
        settle();
        write_reg(REG_BIAS, CFG_DATA_W'(32767));
        close_cfg();
        send_sample(SAMPLE_BITS'(-12345), 1'b0);
        settle();
        apply_cfg(MODE_HARD, 1024, 0, 131071, 4096);
        send_sample(X_MAX, 1'b0);
        send_sample(SAMPLE_BITS'(-777), 1'b1);
        settle();
        apply_cfg(MODE_TAPE, 0, 8000, 65536, 4096);
        send_sample(X_MAX, 1'b0);
        settle();
        apply_cfg(MODE_HARD, 131071, -8000, 65536, 4096);
        send_sample(SAMPLE_BITS'(3), 1'b0);
        settle();
    endtask

    // Dry path at unity level has to pass the sample through untouched
    task automatic test_unity_bypass();
        apply_cfg(MODE_TAPE, 77056, 16384, 0, 4096);
        send_sample(X_MAX, 1'b0);
        send_sample(X_MIN, 1'b0);
        send_sample(pick_sample(), 1'b1);
        settle();
    endtask

    // Writes to unmapped indexes must not disturb any register
    task automatic test_unmapped_index();
        apply_cfg(MODE_HARD, 700, 100, 40000, 3000);
        for (int i = int'(REG_OUT_LEVEL) + 1; i < (1 << CFG_IDX_W); i++) begin
            write_reg(CFG_IDX_W'(i), CFG_DATA_W'($urandom()));
        end
        close_cfg();
        send_sample(SAMPLE_BITS'(2000000), 1'b0);
        send_sample(SAMPLE_BITS'(-5000000), 1'b1);
        settle();
    endtask

    // Random register settings, each followed by a burst of random requests
    task automatic test_random_traffic(int src_pct, int sink_pct, int count);
        int         sent, burst, gain_v, bias_v, mix_v, level_v;
        asat_mode_t mode_v;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        sent          = 0;
        while (sent < count) begin
            mode_v = asat_mode_t'($urandom_range(1));
            case ($urandom_range(9))
                0:       gain_v = 256;
                1:       gain_v = 77056;
                2:       gain_v = 0;
                3:       gain_v = 131071;
                4, 5:    gain_v = $urandom_range(256, 2048);
                default: gain_v = $urandom_range(256, 77056);
            endcase
            case ($urandom_range(7))
                0:       bias_v = 16384;
                1:       bias_v = -16384;
                2:       bias_v = $urandom();
                3:       bias_v = 0;
                default: bias_v = $signed($urandom_range(32768)) - 16384;
            endcase
            case ($urandom_range(7))
                0:       mix_v = 0;
                1:       mix_v = 65536;
                2:       mix_v = $urandom_range(65537, 131071);
                default: mix_v = $urandom_range(65536);
            endcase
            case ($urandom_range(9))
                0:       level_v = 0;
                1:       level_v = 64918;
                2:       level_v = 4096;
                3:       level_v = 65535;
                default: level_v = $urandom_range(64918);
            endcase
            apply_cfg(mode_v, gain_v, bias_v, mix_v, level_v);
            burst = $urandom_range(20, 60);
            repeat (burst) send_sample(pick_sample(), ($urandom_range(7) == 0));
            settle();
            sent += burst;
        end
    endtask

    // Result checker: compare each accepted result against the oldest prediction
    always @(posedge aclk) begin : result_check
        shaped_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (shaped_samples.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual sample_out %0d",
                         $time, $signed(m_tdata[SAMPLE_BITS-1:0]));
                fail_count++;
            end else begin
                want = shaped_samples.pop_front();
                if (m_tdata[SAMPLE_BITS-1:0] !== want.sample) begin
                    $display("%0t: sample_out expected %0d actual %0d", $time,
                             want.sample, $signed(m_tdata[SAMPLE_BITS-1:0]));
                    fail_count++;
                end
                if (m_tlast !== want.last) begin
                    $display("%0t: last_out expected %0b actual %0b", $time, want.last, m_tlast);
                    fail_count++;
                end
                if (m_tuser[0] !== want.clip) begin
                    $display("%0t: clipped expected %0b actual %0b", $time, want.clip, m_tuser[0]);
                    fail_count++;
                end
            end
        end
        m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    initial begin
        fill_seed_table();
        src_idle_pct  = 7;
        sink_idle_pct = 51;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed checks first
        test_reset_defaults();
        test_drive_extremes();
        test_mute();
        test_out_of_range_regs();
        test_unity_bypass();
        test_unmapped_index();

        // Random traffic: slow sink, then slow source, then full rate
        test_random_traffic(7, 51, 570);
        test_random_traffic(51, 7, 570);
        test_random_traffic(0, 0, 570);

        // Let the pipeline run empty before the verdict
        repeat (2 * PIPE_DEPTH) @(posedge aclk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
